### rtl/sorted_table_binary_search_defines.svh
// Assertion macros shared by the sorted table search RTL
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define STS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sts_pkg.sv
// Package: types and constants for the sorted table search block
`timescale 1ns / 1ps

package sts_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 16;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_RESULT
    } sts_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture target, open range
        logic wr_en;     // store one table word
        logic issue;     // read table at midpoint
        logic step;      // narrow range after compare
        logic set_hit;   // record hit at midpoint
        logic set_miss;  // record miss
        logic post;      // move result into output register
    } sts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;     // search range is empty
        logic hit;       // probed word equals target
        logic out_free;  // output register can take a word
    } sts_stat_t;

endpackage

### rtl/sts_ctrl.sv
// Controller: search sequencer state machine
`timescale 1ns / 1ps

module sts_ctrl
    import sts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      mode,
    output logic      in_ready,
    input  sts_stat_t stat,
    output sts_cmd_t  cmd
);

    sts_state_t state_reg;
    sts_state_t state_next;
    logic       accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_SEARCH))
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                state_next = stat.empty ? ST_RESULT : ST_CMP;
            end
            ST_CMP:
            begin
                state_next = stat.hit ? ST_RESULT : ST_PROBE;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.load  = accept && (mode == MODE_SEARCH);
                cmd.wr_en = accept && (mode == MODE_WRITE);
            end
            ST_PROBE:
            begin
                cmd.set_miss = stat.empty;
                cmd.issue    = !stat.empty;
            end
            ST_CMP:
            begin
                cmd.set_hit = stat.hit;
                cmd.step    = !stat.hit;
            end
            ST_RESULT:
            begin
                cmd.post = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/sts_dpath.sv
// Datapath: table memory, search range registers, compare and output register
`timescale 1ns / 1ps

module sts_dpath
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CNT_W-1:0]       cfg_wr_data,
    input  logic [ADDR_W-1:0]      slot,
    input  logic [VALUE_WIDTH-1:0] value,
    input  sts_cmd_t               cmd,
    output sts_stat_t              stat,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic [ADDR_W-1:0]      position
);

    localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(TABLE_DEPTH);
    localparam logic [ADDR_W:0]   DEPTH_ADDR = (ADDR_W + 1)'(TABLE_DEPTH);

    logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

    logic [CNT_W-1:0]       entry_count_reg;
    logic [CNT_W-1:0]       low_reg;
    logic [CNT_W-1:0]       hix_reg;      // exclusive upper bound
    logic [CNT_W-1:0]       mid_reg;
    logic [VALUE_WIDTH-1:0] target_reg;
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   res_found_reg;
    logic [ADDR_W-1:0]      res_pos_reg;
    logic                   out_valid_reg;
    logic                   found_reg;
    logic [ADDR_W-1:0]      position_reg;

    logic [CNT_W-1:0]       count_sat;
    logic [CNT_W:0]         mid_sum;
    logic [CNT_W-1:0]       mid_next;
    logic                   less;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    assign count_sat = (entry_count_reg > DEPTH_CNT) ? DEPTH_CNT : entry_count_reg;

    // floor((low + high) / 2) with high = hix - 1; only used when range is non-empty
    assign mid_sum  = {1'b0, low_reg} + {1'b0, hix_reg} - (CNT_W + 1)'(1);
    assign mid_next = mid_sum[CNT_W:1];

    assign less       = $signed(rd_data_reg) < $signed(target_reg);
    assign stat.empty = (low_reg >= hix_reg);
    assign stat.hit   = (rd_data_reg == target_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && ({1'b0, slot} < DEPTH_ADDR))
        begin
            mem[slot] <= value;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[mid_next[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            target_reg <= value;
            low_reg    <= '0;
            hix_reg    <= count_sat;
        end
        else if (cmd.step)
        begin
            if (less)
            begin
                low_reg <= mid_reg + CNT_W'(1);
            end
            else
            begin
                hix_reg <= mid_reg;
            end
        end
        if (cmd.issue)
        begin
            mid_reg <= mid_next;
        end
        if (cmd.set_hit)
        begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= mid_reg[ADDR_W-1:0];
        end
        else if (cmd.set_miss)
        begin
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
        end
        if (cmd.post)
        begin
            found_reg    <= res_found_reg;
            position_reg <= res_pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.post)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

endmodule

### rtl/sorted_table_binary_search.sv
// Top level: sorted table with binary search lookup
`timescale 1ns / 1ps
`include "sorted_table_binary_search_defines.svh"

// Holds TABLE_DEPTH signed words, loaded one word at a time (mode 0 writes
// value at slot; slots beyond the table are dropped, no result). A search
// word (mode 1) runs a binary search over the first entry_count entries,
// which the user keeps in ascending order, and returns one result word:
// found and the hit slot, or found 0 with position 0 on a miss or when
// entry_count is zero. entry_count above the depth is treated as the depth.
// Sequence: a search runs p probes, each a probe state (range check and
// table read, one read port, registered) then a compare state (compare and
// range update), and ends in a result state that moves the result into
// the output register. A miss passes one more probe state to see the
// empty range; when entry_count is zero that is the only one. p is at most
// 11 for 1024 entries. One search is in flight at a time; in_ready is high
// while no search is running, including while a result waits to be taken.
// Table contents are undefined after reset; searching unwritten entries
// gives unspecified results. No clearing pass is needed.

module sorted_table_binary_search
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: entry_count
    input  logic                   cfg_wr_en,
    input  logic [CNT_W-1:0]       cfg_wr_data,
    // input words
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    input  logic [ADDR_W-1:0]      slot,
    input  logic [VALUE_WIDTH-1:0] value,
    // result words
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic [ADDR_W-1:0]      position
);

    sts_cmd_t  cmd;
    sts_stat_t stat;
    logic      search_acc;   // a search word is taken this cycle

    assign search_acc = in_valid && in_ready && (mode == MODE_SEARCH);

    // sequencer: idle -> probe (range check, issue read) <-> compare -> result; empty range: probe -> result
    sts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, range registers [low, hix), comparator, output register
    sts_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .slot        (slot),
        .value       (value),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .position    (position)
    );

    // a search word keeps the input side closed on the next cycle
    `STS_ASSERT_NEXT(a_busy_after_search, search_acc, !in_ready, "input open after search")
    // a posted result is visible on the next cycle
    `STS_ASSERT_NEXT(a_post_shows, cmd.post, out_valid, "posted result not shown")
    // a memory read is always followed by a compare, never another read
    `STS_ASSERT_NEXT(a_issue_alternates, cmd.issue, !cmd.issue, "back-to-back probe reads")
    // a result is never posted over one that waits
    `STS_ASSERT_IMPLY(a_no_overwrite, cmd.post, !out_valid || out_ready, "result overwritten")

endmodule
